/* design/ate_pkg.sv */
// ate_pkg: shared constants, codes and control structs of the escape parser
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package ate_pkg;

   // sizing
   localparam int MAX_PARAMS = 3;
   localparam int MAX_ROWS   = 48;
   localparam int MAX_RING   = 1024;

   localparam int CHAR_W     = 8;
   localparam int CMD_W      = 2;
   localparam int COL_W      = 8;
   localparam int ROW_W      = $clog2(MAX_ROWS + 1);
   localparam int PROW_W     = $clog2(MAX_RING);
   localparam int RING_W     = $clog2(MAX_RING + 1);
   localparam int PAR_W      = 16;
   localparam int PCNT_W     = $clog2(MAX_PARAMS + 1);
   localparam int PIDX_W     = $clog2(MAX_PARAMS);
   localparam int RED_CNT_W  = $clog2(PROW_W);

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int WREG_W     = 8;
   localparam int HREG_W     = 6;
   localparam int RREG_W     = 11;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RING   = 2'd2;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = 8'd80;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 6'd24;
   localparam logic [RREG_W-1:0] RING_RESET   = 11'd24;

   // result commands
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SGR    = 2'd3;

   // parser modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_CSI    = 2'd2;

   // erase modes
   localparam logic [1:0] ERASE_TO_END   = 2'd0;
   localparam logic [1:0] ERASE_TO_START = 2'd1;
   localparam logic [1:0] ERASE_ALL      = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BEL    = 8'd7;
   localparam logic [CHAR_W-1:0] CH_BS     = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SO     = 8'd14;
   localparam logic [CHAR_W-1:0] CH_SI     = 8'd15;
   localparam logic [CHAR_W-1:0] CH_ESC    = 8'd27;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP     = 8'h41;
   localparam logic [CHAR_W-1:0] CH_DOWN   = 8'h42;
   localparam logic [CHAR_W-1:0] CH_RIGHT  = 8'h43;
   localparam logic [CHAR_W-1:0] CH_LEFT   = 8'h44;
   localparam logic [CHAR_W-1:0] CH_COLABS = 8'h47;
   localparam logic [CHAR_W-1:0] CH_POS    = 8'h48;
   localparam logic [CHAR_W-1:0] CH_POS_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_ED     = 8'h4A;
   localparam logic [CHAR_W-1:0] CH_EL     = 8'h4B;
   localparam logic [CHAR_W-1:0] CH_SGR    = 8'h6D;
   localparam logic [CHAR_W-1:0] CH_SAVE   = 8'h73;
   localparam logic [CHAR_W-1:0] CH_REST   = 8'h75;

   typedef struct packed {
      logic take;
      logic exec;
      logic emit_write;
      logic emit_lf;
      logic emit_row;
      logic emit_sgr;
      logic red_start;
      logic red_step;
   } ate_cmd_type;

   typedef struct packed {
      logic dirty;
      logic csr_fire;
      logic out_free;
      logic lf_emit;
      logic write_need;
      logic rows_need;
      logic sgr_need;
      logic wr_pend;
      logic row_last;
      logic sgr_last;
      logic red_last;
   } ate_status_type;

endpackage

`default_nettype wire

/* design/ate_ifs.sv */
// ate_ifs: valid/ready channel interfaces of the escape parser
// depends on ate_pkg for field widths
`default_nettype none

interface ate_req_if;
   logic                       valid;
   logic                       ready;
   logic [ate_pkg::CHAR_W-1:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface ate_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ate_pkg::CMD_W-1:0]  command;
   logic [ate_pkg::PROW_W-1:0] phys_row;
   logic [ate_pkg::COL_W-1:0]  col_first;
   logic [ate_pkg::COL_W-1:0]  col_last;
   logic [ate_pkg::CHAR_W-1:0] glyph;
   logic [ate_pkg::PAR_W-1:0]  sgr_value;
   logic                       last_of_run;
   modport source (output valid, output command, output phys_row, output col_first,
                   output col_last, output glyph, output sgr_value, output last_of_run,
                   input ready);
   modport sink (input valid, input command, input phys_row, input col_first,
                 input col_last, input glyph, input sgr_value, input last_of_run,
                 output ready);
endinterface

interface ate_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ate_pkg::CSR_IDX_W-1:0]  index;
   logic [ate_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/ate_ctrl.sv */
// ate_ctrl: sequencing state machine of the escape parser
// depends on ate_pkg; drives the datapath through ate_cmd_type
`default_nettype none

module ate_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ate_pkg::ate_status_type status,
   output ate_pkg::ate_cmd_type         cmd
);
   import ate_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RED  = 7'b0000010,
      ST_EXEC = 7'b0000100,
      ST_LF   = 7'b0001000,
      ST_WR   = 7'b0010000,
      ST_ROWS = 7'b0100000,
      ST_SGR  = 7'b1000000
   } ate_state_type;

   ate_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (status.dirty) begin
               cmd.red_start = 1'b1;
               state_in      = ST_RED;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.take = 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_RED: begin
            cmd.red_step = 1'b1;
            // a register write restarts the pass
            if (status.csr_fire || status.red_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.lf_emit) begin
               state_in = ST_LF;
            end else if (status.write_need) begin
               if (status.out_free) begin
                  cmd.emit_write = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_WR;
               end
            end else if (status.rows_need) begin
               state_in = ST_ROWS;
            end else if (status.sgr_need) begin
               state_in = ST_SGR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LF: begin
            if (status.out_free) begin
               cmd.emit_lf = 1'b1;
               state_in    = status.wr_pend ? ST_WR : ST_IDLE;
            end
         end
         ST_WR: begin
            if (status.out_free) begin
               cmd.emit_write = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ROWS: begin
            if (status.out_free) begin
               cmd.emit_row = 1'b1;
               if (status.row_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SGR: begin
            if (status.out_free) begin
               cmd.emit_sgr = 1'b1;
               if (status.sgr_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/ate_datapath.sv */
// ate_datapath: parser state, registers, row and ring arithmetic, result register
// depends on ate_pkg and ate_ifs; controlled by ate_ctrl
`default_nettype none

module ate_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [ate_pkg::CHAR_W-1:0]  char_code,
   input  wire ate_pkg::ate_cmd_type        cmd,
   output ate_pkg::ate_status_type          status,
   ate_rsp_if.source                        rsp_bus,
   ate_csr_if.sink                          csr_bus
);
   import ate_pkg::*;

   // registers
   logic [WREG_W-1:0]    width_ff;
   logic [HREG_W-1:0]    height_ff;
   logic [RREG_W-1:0]    ring_ff;
   logic                 dirty_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [1:0]           mode_ff;
   logic [COL_W-1:0]     cc_ff, sc_ff;
   logic [ROW_W-1:0]     cr_ff, sr_ff;
   logic [PAR_W-1:0]     params_ff [MAX_PARAMS];
   logic [PCNT_W-1:0]    pcnt_ff;
   logic [PROW_W-1:0]    base_ff;
   logic                 wr_pend_ff;
   logic [1:0]           em_ff;
   logic [ROW_W-1:0]     row_ff, hi_ff;
   logic [PIDX_W-1:0]    sidx_ff;
   logic [RING_W-1:0]    red_rem_ff;
   logic [PROW_W-1:0]    red_sh_ff;
   logic [RED_CNT_W-1:0] red_cnt_ff;
   logic                 out_valid_ff;
   logic [CMD_W-1:0]     out_cmd_ff;
   logic [PROW_W-1:0]    out_row_ff;
   logic [COL_W-1:0]     out_c0_ff, out_c1_ff;
   logic [CHAR_W-1:0]    out_glyph_ff;
   logic [PAR_W-1:0]     out_sgr_ff;
   logic                 out_last_ff;

   // decode results
   logic [1:0]        mode_in;
   logic [COL_W-1:0]  cc_in, sc_in;
   logic [ROW_W-1:0]  cr_in, sr_in;
   logic [PAR_W-1:0]  params_in [MAX_PARAMS];
   logic [PCNT_W-1:0] pcnt_in;
   logic [PROW_W-1:0] base_in;
   logic [1:0]        em_in;
   logic [ROW_W-1:0]  lo_in, hi_in;
   logic              do_lf, lf_emit, write_need, rows_need, sgr_need;

   // working values
   logic [COL_W-1:0]     eff_w, w_m1, lastc;
   logic [ROW_W-1:0]     eff_h, h_m1, cr, lf_row;
   logic [RING_W-1:0]    eff_ring;
   logic                 lf_scroll;
   logic [PROW_W-1:0]    base_inc;
   logic [RING_W-1:0]    base_sum;
   logic [PAR_W-1:0]     p0, fp, fp_m1, sp_m1, pv;
   logic [PAR_W+3:0]     dv;
   logic [PAR_W:0]       rsum, csum;
   logic [COL_W:0]       tv;
   logic [PIDX_W-1:0]    pidx;
   logic                 is_digit, csr_fire, load, out_free, row_last, sgr_last, red_last;
   logic [RING_W:0]      red_t, red_next;
   logic [COL_W-1:0]     wr_col;
   logic [ROW_W-1:0]     wr_row;
   logic [CMD_W-1:0]     o_cmd;
   logic [PROW_W-1:0]    o_row;
   logic [COL_W-1:0]     o_c0, o_c1;
   logic [CHAR_W-1:0]    o_glyph;
   logic [PAR_W-1:0]     o_sgr;
   logic                 o_last;

   function automatic logic [PROW_W-1:0] phys_of(input logic [PROW_W-1:0] base,
                                                 input logic [ROW_W-1:0] r,
                                                 input logic [RING_W-1:0] ring);
      logic [RING_W:0] s;
      s = (RING_W+1)'(base) + (RING_W+1)'(r);
      if (s >= (RING_W+1)'(ring)) begin
         s = s - (RING_W+1)'(ring);
      end
      return s[PROW_W-1:0];
   endfunction

   // effective geometry
   always_comb begin
      eff_w = (width_ff == '0) ? COL_W'(1) : COL_W'(width_ff);
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (ROW_W'(height_ff) > ROW_W'(MAX_ROWS)) begin
         eff_h = ROW_W'(MAX_ROWS);
      end else begin
         eff_h = ROW_W'(height_ff);
      end
      if (RING_W'(ring_ff) < RING_W'(eff_h)) begin
         eff_ring = RING_W'(eff_h);
      end else if (RING_W'(ring_ff) > RING_W'(MAX_RING)) begin
         eff_ring = RING_W'(MAX_RING);
      end else begin
         eff_ring = RING_W'(ring_ff);
      end
      w_m1      = eff_w - COL_W'(1);
      h_m1      = eff_h - ROW_W'(1);
      cr        = (cr_ff >= eff_h) ? h_m1 : cr_ff;
      lastc     = (cc_ff < eff_w) ? cc_ff : w_m1;
      lf_scroll = (cr == h_m1);
      lf_row    = lf_scroll ? h_m1 : cr + ROW_W'(1);
      base_sum  = RING_W'(base_ff) + RING_W'(1);
      base_inc  = (base_sum == eff_ring) ? '0 : base_sum[PROW_W-1:0];
   end

   // decode of the latched byte
   always_comb begin
      mode_in    = mode_ff;
      cc_in      = cc_ff;
      cr_in      = cr;
      sc_in      = sc_ff;
      sr_in      = sr_ff;
      params_in  = params_ff;
      pcnt_in    = pcnt_ff;
      base_in    = base_ff;
      em_in      = em_ff;
      lo_in      = '0;
      hi_in      = '0;
      do_lf      = 1'b0;
      lf_emit    = 1'b0;
      write_need = 1'b0;
      rows_need  = 1'b0;
      sgr_need   = 1'b0;
      p0         = params_ff[0];
      fp         = (p0 == '0) ? PAR_W'(1) : p0;
      fp_m1      = fp - PAR_W'(1);
      sp_m1      = (params_ff[1] == '0) ? '0 : params_ff[1] - PAR_W'(1);
      pidx       = pcnt_ff[PIDX_W-1:0];
      pv         = params_ff[pidx];
      dv         = (PAR_W+4)'({pv, 3'b000}) + (PAR_W+4)'({pv, 1'b0})
                   + (PAR_W+4)'(char_ff - CH_0);
      rsum       = (PAR_W+1)'(fp) + (PAR_W+1)'(cr);
      csum       = (PAR_W+1)'(fp) + (PAR_W+1)'(cc_ff);
      tv         = (COL_W+1)'(cc_ff | COL_W'(7)) + (COL_W+1)'(1);
      is_digit   = (char_ff >= CH_0) && (char_ff <= CH_9);

      if (mode_ff == MODE_ESC) begin
         if (char_ff == CH_LBRACK) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
               params_in[i] = '0;
            end
            pcnt_in = '0;
            mode_in = MODE_CSI;
         end else begin
            mode_in = MODE_NORMAL;
         end
      end else if (mode_ff == MODE_CSI) begin
         if (is_digit) begin
            if (pcnt_ff < PCNT_W'(MAX_PARAMS)) begin
               params_in[pidx] = (dv[PAR_W+3:PAR_W] != '0) ? '1 : dv[PAR_W-1:0];
            end
         end else begin
            if (pcnt_ff < PCNT_W'(MAX_PARAMS)) begin
               pcnt_in = pcnt_ff + PCNT_W'(1);
            end
            if (char_ff != CH_SEMI) begin
               mode_in = MODE_NORMAL;
               case (char_ff)
                  CH_UP: begin
                     cr_in = (fp > PAR_W'(cr)) ? '0 : cr - fp[ROW_W-1:0];
                  end
                  CH_DOWN: begin
                     cr_in = (rsum >= (PAR_W+1)'(eff_h)) ? h_m1 : rsum[ROW_W-1:0];
                  end
                  CH_RIGHT: begin
                     cc_in = (csum >= (PAR_W+1)'(eff_w)) ? w_m1 : csum[COL_W-1:0];
                  end
                  CH_LEFT: begin
                     cc_in = (fp > PAR_W'(cc_ff)) ? '0 : cc_ff - fp[COL_W-1:0];
                  end
                  CH_COLABS: begin
                     cc_in = (fp_m1 >= PAR_W'(eff_w)) ? w_m1 : fp_m1[COL_W-1:0];
                  end
                  CH_POS, CH_POS_F: begin
                     cc_in = (sp_m1 >= PAR_W'(eff_w)) ? w_m1 : sp_m1[COL_W-1:0];
                     cr_in = (fp_m1 >= PAR_W'(eff_h)) ? h_m1 : fp_m1[ROW_W-1:0];
                  end
                  CH_ED: begin
                     em_in = p0[1:0];
                     if (p0 == PAR_W'(ERASE_TO_END)) begin
                        lo_in     = (cc_ff < eff_w) ? cr : cr + ROW_W'(1);
                        hi_in     = h_m1;
                        rows_need = (cc_ff < eff_w) || (cr != h_m1);
                     end else if (p0 == PAR_W'(ERASE_TO_START)) begin
                        hi_in     = cr;
                        rows_need = 1'b1;
                     end else if (p0 == PAR_W'(ERASE_ALL)) begin
                        hi_in     = h_m1;
                        rows_need = 1'b1;
                     end
                  end
                  CH_EL: begin
                     em_in = p0[1:0];
                     lo_in = cr;
                     hi_in = cr;
                     if (p0 == PAR_W'(ERASE_TO_END)) begin
                        rows_need = (cc_ff < eff_w);
                     end else if (p0 == PAR_W'(ERASE_TO_START) ||
                                  p0 == PAR_W'(ERASE_ALL)) begin
                        rows_need = 1'b1;
                     end
                  end
                  CH_SGR: begin
                     sgr_need = (pcnt_in != '0);
                  end
                  CH_SAVE: begin
                     sc_in = cc_ff;
                     sr_in = cr;
                  end
                  CH_REST: begin
                     cc_in = sc_ff;
                     cr_in = (sr_ff >= eff_h) ? h_m1 : sr_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end else begin
         mode_in = MODE_NORMAL;
         case (char_ff)
            CH_CR: begin
               cc_in = '0;
            end
            CH_LF: begin
               do_lf = 1'b1;
            end
            CH_BS: begin
               if (cc_ff != '0) begin
                  cc_in = cc_ff - COL_W'(1);
               end
            end
            CH_TAB: begin
               if (tv > (COL_W+1)'(eff_w)) begin
                  cc_in = '0;
                  do_lf = 1'b1;
               end else begin
                  cc_in = tv[COL_W-1:0];
               end
            end
            CH_BEL, CH_SO, CH_SI: begin
            end
            CH_ESC: begin
               mode_in = MODE_ESC;
            end
            default: begin
               write_need = 1'b1;
               if (cc_ff >= eff_w) begin
                  cc_in = '0;
                  do_lf = 1'b1;
               end
            end
         endcase
      end

      if (do_lf) begin
         cr_in   = lf_row;
         lf_emit = lf_scroll;
         if (lf_scroll) begin
            base_in = base_inc;
         end
      end
   end

   // remainder step for ring base reduction
   always_comb begin
      red_t    = {red_rem_ff, red_sh_ff[PROW_W-1]};
      red_next = (red_t >= (RING_W+1)'(eff_ring)) ? red_t - (RING_W+1)'(eff_ring) : red_t;
      red_last = (red_cnt_ff == RED_CNT_W'(PROW_W - 1));
   end

   // result selection
   always_comb begin
      row_last = (row_ff == hi_ff);
      sgr_last = (PCNT_W'(sidx_ff) + PCNT_W'(1)) == pcnt_ff;
      // a write issued in the decode cycle lands at the decoded cursor
      wr_col   = cmd.exec ? cc_in : cc_ff;
      wr_row   = cmd.exec ? cr_in : cr;
      o_cmd    = CMD_WRITE;
      o_row    = '0;
      o_c0     = '0;
      o_c1     = '0;
      o_glyph  = '0;
      o_sgr    = '0;
      o_last   = 1'b1;
      if (cmd.emit_write) begin
         o_row   = phys_of(base_ff, wr_row, eff_ring);
         o_c0    = wr_col;
         o_c1    = wr_col;
         o_glyph = char_ff;
      end else if (cmd.emit_lf) begin
         o_cmd  = CMD_SCROLL;
         o_row  = phys_of(base_ff, h_m1, eff_ring);
         o_c1   = w_m1;
         o_last = !wr_pend_ff;
      end else if (cmd.emit_row) begin
         o_cmd  = CMD_CLEAR;
         o_row  = phys_of(base_ff, row_ff, eff_ring);
         o_c0   = (em_ff == ERASE_TO_END && row_ff == cr) ? cc_ff : '0;
         o_c1   = (em_ff == ERASE_TO_START && row_ff == cr) ? lastc : w_m1;
         o_last = row_last;
      end else if (cmd.emit_sgr) begin
         o_cmd  = CMD_SGR;
         o_sgr  = params_ff[sidx_ff];
         o_last = sgr_last;
      end
   end

   assign csr_fire = csr_bus.valid;
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign load     = cmd.emit_write || cmd.emit_lf || cmd.emit_row || cmd.emit_sgr;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         ring_ff      <= RING_RESET;
         dirty_ff     <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         cc_ff        <= '0;
         cr_ff        <= '0;
         sc_ff        <= '0;
         sr_ff        <= '0;
         pcnt_ff      <= '0;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PARAMS; i++) begin
            params_ff[i] <= '0;
         end
      end else begin
         if (csr_fire) begin
            case (csr_bus.index)
               REG_WIDTH:  width_ff  <= csr_bus.data[WREG_W-1:0];
               REG_HEIGHT: height_ff <= csr_bus.data[HREG_W-1:0];
               REG_RING:   ring_ff   <= csr_bus.data[RREG_W-1:0];
               default: begin
               end
            endcase
         end
         if (csr_fire) begin
            dirty_ff <= 1'b1;
         end else if (cmd.red_step && red_last) begin
            dirty_ff <= 1'b0;
            base_ff  <= red_next[PROW_W-1:0];
         end
         if (cmd.exec) begin
            mode_ff   <= mode_in;
            cc_ff     <= cmd.emit_write ? cc_in + COL_W'(1) : cc_in;
            cr_ff     <= cr_in;
            sc_ff     <= sc_in;
            sr_ff     <= sr_in;
            params_ff <= params_in;
            pcnt_ff   <= pcnt_in;
            base_ff   <= base_in;
         end
         if (cmd.emit_write && !cmd.exec) begin
            cc_ff <= cc_ff + COL_W'(1);
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // work registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         char_ff <= char_code;
      end
      if (cmd.exec) begin
         wr_pend_ff <= write_need;
         em_ff      <= em_in;
         row_ff     <= lo_in;
         hi_ff      <= hi_in;
         sidx_ff    <= '0;
      end
      if (cmd.emit_row) begin
         row_ff <= row_ff + ROW_W'(1);
      end
      if (cmd.emit_sgr) begin
         sidx_ff <= sidx_ff + PIDX_W'(1);
      end
      if (cmd.red_start) begin
         red_sh_ff  <= base_ff;
         red_rem_ff <= '0;
         red_cnt_ff <= '0;
      end else if (cmd.red_step) begin
         red_sh_ff  <= {red_sh_ff[PROW_W-2:0], 1'b0};
         red_rem_ff <= red_next[RING_W-1:0];
         red_cnt_ff <= red_cnt_ff + RED_CNT_W'(1);
      end
      if (load) begin
         out_cmd_ff   <= o_cmd;
         out_row_ff   <= o_row;
         out_c0_ff    <= o_c0;
         out_c1_ff    <= o_c1;
         out_glyph_ff <= o_glyph;
         out_sgr_ff   <= o_sgr;
         out_last_ff  <= o_last;
      end
   end

   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.command     = out_cmd_ff;
   assign rsp_bus.phys_row    = out_row_ff;
   assign rsp_bus.col_first   = out_c0_ff;
   assign rsp_bus.col_last    = out_c1_ff;
   assign rsp_bus.glyph       = out_glyph_ff;
   assign rsp_bus.sgr_value   = out_sgr_ff;
   assign rsp_bus.last_of_run = out_last_ff;

   always_comb begin
      status            = '0;
      status.dirty      = dirty_ff;
      status.csr_fire   = csr_fire;
      status.out_free   = out_free;
      status.lf_emit    = lf_emit;
      status.write_need = write_need;
      status.rows_need  = rows_need;
      status.sgr_need   = sgr_need;
      status.wr_pend    = wr_pend_ff;
      status.row_last   = row_last;
      status.sgr_last   = sgr_last;
      status.red_last   = red_last;
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free) else $error("result overwritten before transfer");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_write, cmd.emit_lf, cmd.emit_row, cmd.emit_sgr}))
      else $error("two result sources at once");

   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      !dirty_ff |-> (RING_W'(base_ff) < eff_ring)) else $error("ring base out of ring");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      cr_ff < ROW_W'(MAX_ROWS)) else $error("cursor row past row limit");

endmodule

`default_nettype wire

/* design/ansi_terminal_escape_parser.sv */
// ansi_terminal_escape_parser: top level of the VT100-style CSI escape parser
// depends on ate_pkg, ate_ifs, ate_ctrl and ate_datapath
//
// usage
//  - req_bus carries one character byte per transfer; rsp_bus returns the
//    cell ring commands it causes (write, scroll-and-clear, clear span, SGR),
//    last_of_run marks the final result of a byte; many bytes give none
//  - csr_bus writes screen_width (0), screen_height (1), ring_rows (2);
//    always ready; the user must have them written only while the block is idle, the block does not enforce it
//  - one byte is in work at a time: the byte is latched in the transfer cycle
//    and decoded in the next; a plain write gives one result, a wrapping write
//    at the bottom row a scroll and then the write, an erase one clear per
//    cleared row (up to 48), SGR one result per parameter
//  - results are registered in the output register before they leave
//  - after any register write the ring base is reduced modulo the ring by a
//    bit-serial remainder pass before the next byte is taken
//  - when the receiver stalls, the single output register holds its result
//    and the sequencer waits; nothing is dropped
//  - reset (synchronous, active high) restores 80 x 24 with a 24-row ring,
//    home cursor, normal parse mode and an empty output register
`default_nettype none

module ansi_terminal_escape_parser (
   input wire logic  clock,
   input wire logic  reset,
   ate_req_if.sink   req_bus,
   ate_rsp_if.source rsp_bus,
   ate_csr_if.sink   csr_bus
);
   import ate_pkg::*;

   // control handoff between sequencer and datapath
   ate_cmd_type    cmd;
   ate_status_type status;

   // sequencer: byte intake, decode, per-result emission, ring reduction
   ate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: parser state, geometry registers and the output register
   ate_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .char_code (req_bus.char_code),
      .cmd       (cmd),
      .status    (status),
      .rsp_bus   (rsp_bus),
      .csr_bus   (csr_bus)
   );

endmodule

`default_nettype wire

/* tb/ansi_terminal_escape_parser_tb.sv */
// ansi_terminal_escape_parser_tb: self-checking bench for the escape parser
// depends on ate_pkg, ate_ifs and the ansi_terminal_escape_parser top level
// a directed table of bytes and random terminal traffic, checked against a screen predictor
`timescale 1ns / 1ps

module ansi_terminal_escape_parser_tb;
   import ate_pkg::*;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PROW_W-1:0] phys_row;
      logic [COL_W-1:0]  col_first;
      logic [COL_W-1:0]  col_last;
      logic [CHAR_W-1:0] glyph;
      logic [PAR_W-1:0]  sgr_value;
      logic              last_of_run;
   } cell_cmd_t;

   typedef struct {
      logic [7:0] code;
      bit         has_exp;
      cell_cmd_t  exp_cmd;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ate_req_if req_bus ();
   ate_rsp_if rsp_bus ();
   ate_csr_if csr_bus ();

   ansi_terminal_escape_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // predictor state: registers and parser state
   int unsigned scr_w, scr_h, ring_n;
   int unsigned mode, cur_col, cur_row, sav_col, sav_row, par_cnt, base;
   int unsigned params[MAX_PARAMS];
   int unsigned ew, eh, ering;

   cell_cmd_t pending_cmds[$];
   cell_cmd_t step_cmds[$];
   int        err_cnt = 0;
   int        got_cnt = 0;
   bit        rx_calm = 1'b0;
   bit        tx_calm = 1'b0;
   stim_row_t dir_tab[$];

   function automatic void push_cmd(int unsigned c, int unsigned r, int unsigned c0,
                                    int unsigned c1, int unsigned g, int unsigned s);
      cell_cmd_t e;
      e.command     = c[CMD_W-1:0];
      e.phys_row    = r[PROW_W-1:0];
      e.col_first   = c0[7:0];
      e.col_last    = c1[7:0];
      e.glyph       = g[7:0];
      e.sgr_value   = s[15:0];
      e.last_of_run = 1'b0;
      step_cmds.push_back(e);
   endfunction

   function automatic int unsigned ring_row(int unsigned r);
      return (base + r) % ering;
   endfunction

   function automatic void new_line();
      cur_row++;
      if (cur_row >= eh) begin
         cur_row = eh - 1;
         base = (base + 1) % ering;
         push_cmd(CMD_SCROLL, ring_row(eh - 1), 0, ew - 1, 0, 0);
      end
   endfunction

   function automatic void run_final(logic [7:0] ch);
      int unsigned p, lastc, r, p0;
      p0 = params[0] == 0 ? 1 : params[0];
      lastc = cur_col < ew ? cur_col : ew - 1;
      case (ch)
         CH_UP: cur_row = p0 > cur_row ? 0 : cur_row - p0;
         CH_DOWN: cur_row = (cur_row + p0 >= eh) ? eh - 1 : cur_row + p0;
         CH_RIGHT: cur_col = (cur_col + p0 >= ew) ? ew - 1 : cur_col + p0;
         CH_LEFT: cur_col = p0 > cur_col ? 0 : cur_col - p0;
         CH_COLABS: cur_col = (p0 - 1 >= ew) ? ew - 1 : p0 - 1;
         CH_POS, CH_POS_F: begin
            p = (params[1] == 0 ? 1 : params[1]) - 1;
            cur_col = p >= ew ? ew - 1 : p;
            cur_row = (p0 - 1 >= eh) ? eh - 1 : p0 - 1;
         end
         CH_ED: begin
            if (params[0] == ERASE_TO_END) begin
               if (cur_col < ew) push_cmd(CMD_CLEAR, ring_row(cur_row), cur_col, ew - 1, 0, 0);
               for (r = cur_row + 1; r < eh; r++) push_cmd(CMD_CLEAR, ring_row(r), 0, ew - 1, 0, 0);
            end else if (params[0] == ERASE_TO_START) begin
               for (r = 0; r < cur_row; r++) push_cmd(CMD_CLEAR, ring_row(r), 0, ew - 1, 0, 0);
               push_cmd(CMD_CLEAR, ring_row(cur_row), 0, lastc, 0, 0);
            end else if (params[0] == ERASE_ALL) begin
               for (r = 0; r < eh; r++) push_cmd(CMD_CLEAR, ring_row(r), 0, ew - 1, 0, 0);
            end
         end
         CH_EL: begin
            if (params[0] == ERASE_TO_END) begin
               if (cur_col < ew) push_cmd(CMD_CLEAR, ring_row(cur_row), cur_col, ew - 1, 0, 0);
            end else if (params[0] == ERASE_TO_START) begin
               push_cmd(CMD_CLEAR, ring_row(cur_row), 0, lastc, 0, 0);
            end else if (params[0] == ERASE_ALL) begin
               push_cmd(CMD_CLEAR, ring_row(cur_row), 0, ew - 1, 0, 0);
            end
         end
         CH_SGR: for (r = 0; r < par_cnt && r < MAX_PARAMS; r++) push_cmd(CMD_SGR, 0, 0, 0, 0, params[r]);
         CH_SAVE: begin
            sav_col = cur_col;
            sav_row = cur_row;
         end
         CH_REST: begin
            cur_col = sav_col;
            cur_row = sav_row >= eh ? eh - 1 : sav_row;
         end
         default: ;
      endcase
   endfunction

   // predicts the cell commands of one byte and queues them
   function automatic void predict_byte(logic [7:0] ch);
      int unsigned v;
      step_cmds.delete();
      ew = scr_w == 0 ? 1 : scr_w;
      eh = scr_h == 0 ? 1 : scr_h;
      if (eh > MAX_ROWS) eh = MAX_ROWS;
      ering = ring_n < eh ? eh : ring_n;
      if (ering > MAX_RING) ering = MAX_RING;
      base = base % ering;
      if (cur_row >= eh) cur_row = eh - 1;
      if (mode == MODE_ESC) begin
         if (ch == CH_LBRACK) begin
            foreach (params[i]) params[i] = 0;
            par_cnt = 0;
            mode = MODE_CSI;
         end else mode = MODE_NORMAL;
      end else if (mode == MODE_CSI) begin
         if (ch >= CH_0 && ch <= CH_9) begin
            if (par_cnt < MAX_PARAMS) begin
               v = params[par_cnt] * 10 + (ch - CH_0);
               params[par_cnt] = v > 65535 ? 65535 : v;
            end
         end else begin
            if (par_cnt < MAX_PARAMS) par_cnt++;
            if (ch != CH_SEMI) begin
               mode = MODE_NORMAL;
               run_final(ch);
            end
         end
      end else begin
         mode = MODE_NORMAL;
         case (ch)
            CH_CR: cur_col = 0;
            CH_LF: new_line();
            CH_BS: if (cur_col > 0) cur_col--;
            CH_TAB: begin
               v = cur_col + (8 - cur_col % 8);
               if (v > ew) begin
                  cur_col = 0;
                  new_line();
               end else cur_col = v;
            end
            CH_BEL, CH_SO, CH_SI: ;
            CH_ESC: mode = MODE_ESC;
            default: begin
               if (cur_col >= ew) begin
                  cur_col = 0;
                  new_line();
               end
               push_cmd(CMD_WRITE, ring_row(cur_row), cur_col, cur_col, ch, 0);
               cur_col++;
            end
         endcase
      end
      if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last_of_run = 1'b1;
      foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
   endfunction

   // result side: random stall, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            cell_cmd_t e;
            got_cnt++;
            if (pending_cmds.size() == 0) begin
               $error("unexpected result command=%0d", rsp_bus.command);
               err_cnt++;
            end else begin
               e = pending_cmds.pop_front();
               if (rsp_bus.command !== e.command) begin
                  $error("command exp %0d got %0d", e.command, rsp_bus.command); err_cnt++;
               end
               if (rsp_bus.phys_row !== e.phys_row) begin
                  $error("phys_row exp %0d got %0d", e.phys_row, rsp_bus.phys_row); err_cnt++;
               end
               if (rsp_bus.col_first !== e.col_first) begin
                  $error("col_first exp %0d got %0d", e.col_first, rsp_bus.col_first); err_cnt++;
               end
               if (rsp_bus.col_last !== e.col_last) begin
                  $error("col_last exp %0d got %0d", e.col_last, rsp_bus.col_last); err_cnt++;
               end
               if (rsp_bus.glyph !== e.glyph) begin
                  $error("glyph exp %0d got %0d", e.glyph, rsp_bus.glyph); err_cnt++;
               end
               if (rsp_bus.sgr_value !== e.sgr_value) begin
                  $error("sgr_value exp %0d got %0d", e.sgr_value, rsp_bus.sgr_value); err_cnt++;
               end
               if (rsp_bus.last_of_run !== e.last_of_run) begin
                  $error("last_of_run exp %0d got %0d", e.last_of_run, rsp_bus.last_of_run);
                  err_cnt++;
               end
            end
         end
         rsp_bus.ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 9);
      end
   end

   // one byte transfer, with random idle cycles in front; valid stays up after it
   task automatic send_byte(logic [7:0] ch);
      while (!tx_calm && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= ch;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_byte(ch);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == REG_WIDTH) scr_w = val & 8'hFF;
      else if (idx == REG_HEIGHT) scr_h = val & 6'h3F;
      else if (idx == REG_RING) ring_n = val & 11'h7FF;
   endtask

   task automatic set_screen(int unsigned w, int unsigned h, int unsigned r);
      drain();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_RING, r);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic void add_row(logic [7:0] ch);
      stim_row_t s;
      s.code = ch;
      s.has_exp = 1'b0;
      s.exp_cmd = '0;
      dir_tab.push_back(s);
   endfunction

   function automatic void add_exp(logic [7:0] ch, cell_cmd_t e);
      stim_row_t s;
      s.code = ch;
      s.has_exp = 1'b1;
      s.exp_cmd = e;
      dir_tab.push_back(s);
   endfunction

   task automatic send_str(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // random byte, biased toward well-formed escape sequences
   task automatic random_traffic(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 40) send_byte(8'($urandom_range(32, 126)));
         else if (k < 50) begin
            case ($urandom_range(5))
               0: send_byte(CH_CR);
               1: send_byte(CH_LF);
               2: send_byte(CH_BS);
               3: send_byte(CH_TAB);
               4: send_byte(CH_BEL);
               default: send_byte(CH_SO);
            endcase
         end else if (k < 88) begin
            string finals;
            int np;
            finals = "ABCDGHfJKmsuJKm";
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            np = $urandom_range(4);
            for (int p = 0; p < np; p++) begin
               int nd;
               nd = ($urandom_range(9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 2);
               for (int d = 0; d < nd; d++) send_byte(8'(CH_0 + $urandom_range(9)));
               if (p != np - 1) send_byte(CH_SEMI);
            end
            send_byte(finals[$urandom_range(finals.len() - 1)]);
            i += 2;
         end else if (k < 93) begin
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(255)));
         end else send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      scr_w = WIDTH_RESET; scr_h = HEIGHT_RESET; ring_n = RING_RESET;
      mode = MODE_NORMAL; cur_col = 0; cur_row = 0; sav_col = 0; sav_row = 0;
      par_cnt = 0; base = 0;
      foreach (params[i]) params[i] = 0;
      req_bus.valid = 1'b0; req_bus.char_code = '0;
      csr_bus.valid = 1'b0; csr_bus.index = '0; csr_bus.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: plain writes at home with the reset screen
      add_exp(8'h41, '{CMD_WRITE, 10'd0, 8'd0, 8'd0, 8'h41, 16'd0, 1'b1});
      add_exp(8'hFF, '{CMD_WRITE, 10'd0, 8'd1, 8'd1, 8'hFF, 16'd0, 1'b1});
      add_exp(8'h00, '{CMD_WRITE, 10'd0, 8'd2, 8'd2, 8'h00, 16'd0, 1'b1});
      add_row(CH_BEL); add_row(CH_SO); add_row(CH_SI); add_row(CH_BS);
      add_row(CH_TAB); add_row(CH_CR); add_row(CH_LF);
      // esc then a non-bracket byte is dropped
      add_row(CH_ESC); add_row(8'h58);
      // sgr with saturating parameter and extra parameter ignored
      add_row(CH_ESC); add_row(CH_LBRACK);
      add_row(8'h39); add_row(8'h39); add_row(8'h39); add_row(8'h39); add_row(8'h39);
      add_row(CH_SEMI); add_row(8'h31); add_row(CH_SEMI); add_row(CH_SEMI); add_row(8'h37);
      add_row(CH_SGR);
      foreach (dir_tab[i]) begin
         send_byte(dir_tab[i].code);
         if (dir_tab[i].has_exp) begin
            if (step_cmds.size() != 1 || step_cmds[0] !== dir_tab[i].exp_cmd) begin
               $error("directed row %0d: predictor disagrees with table", i);
               err_cnt++;
            end
         end
      end

      // sender holds off until every result is back
      drain();
      // cursor moves, erase modes, save/restore, n and ignored finals
      send_str("\033[5;70H\033[s\033[J\033[1J\033[2J\033[3J\033[K\033[1K\033[2K\033[9K");
      send_str("\033[A\033[99B\033[0C\033[300D\033[0G\033[999G\033[u\033[6n\033[5f\033[m");

      // narrowest and tallest screens, largest ring
      set_screen(1, 48, 1024);
      send_str("ab\t\n\033[2J\033[0Jxyz\033[K");
      set_screen(0, 0, 0);
      send_str("qq\n\t\033[1J\033[2J");
      set_screen(255, 63, 2047);
      send_str("\033[99;300H\t\tz\033[J");
      set_screen(80, 24, 24);

      tx_calm = 1'b1; rx_calm = 1'b1;
      random_traffic(20);
      tx_calm = 1'b0; rx_calm = 1'b0;
      random_traffic(40);
      set_screen(7, 3, 5);
      random_traffic(25);
      set_screen($urandom_range(1, 40), $urandom_range(1, 10), $urandom_range(1, 40));
      random_traffic(25);

      drain();
      $display("covered %0d results over directed control, csi and erase cases", got_cnt);
      $display("and random traffic on several screen and ring sizes");
      if (err_cnt == 0 && pending_cmds.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
